@@ hw/rtl/rtrs_pkg.sv @@
package rtrs_pkg;

   localparam int MAX_ITEMS = 64;
   localparam int IDX_W     = $clog2(MAX_ITEMS);
   localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
   localparam int VAL_W     = 32;
   localparam int POS_W     = 6;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SCAN,
      ST_SCAN_WAIT,
      ST_COMMIT,
      ST_EMIT_ORD,
      ST_EMIT_VAL,
      ST_EMIT_OUT
   } state_type;

   typedef struct packed {
      logic load_en;
      logic scan_issue;
      logic commit;
      logic emit_ord;
      logic emit_val;
      logic emit_load;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic last_accepted;
      logic scan_last;
      logic rank_last;
      logic emit_last;
      logic out_free;
   } sts_type;

endpackage

@@ hw/rtl/rtrs_ctrl.sv @@
module rtrs_ctrl
   import rtrs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (sts.last_accepted) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (sts.scan_last) state_in = ST_SCAN_WAIT;
         end
         ST_SCAN_WAIT: state_in = ST_COMMIT;
         ST_COMMIT: begin
            if (sts.rank_last) state_in = ST_EMIT_ORD;
            else state_in = ST_SCAN;
         end
         ST_EMIT_ORD: state_in = ST_EMIT_VAL;
         ST_EMIT_VAL: state_in = ST_EMIT_OUT;
         ST_EMIT_OUT: begin
            if (sts.out_free) begin
               if (sts.emit_last) state_in = ST_LOAD;
               else state_in = ST_EMIT_ORD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_LOAD:      cmd.load_en    = 1'b1;
         ST_SCAN:      cmd.scan_issue = 1'b1;
         ST_SCAN_WAIT: ;
         ST_COMMIT:    cmd.commit     = 1'b1;
         ST_EMIT_ORD:  cmd.emit_ord   = 1'b1;
         ST_EMIT_VAL:  cmd.emit_val   = 1'b1;
         ST_EMIT_OUT: begin
            cmd.emit_load = sts.out_free;
            cmd.finish    = sts.out_free & sts.emit_last;
         end
         default: ;
      endcase
   end

endmodule

@@ hw/rtl/rtrs_dpath.sv @@
module rtrs_dpath
   import rtrs_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output sts_type                 sts,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic signed [VAL_W-1:0] in_number,
   input  logic                    in_last,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic signed [VAL_W-1:0] out_value,
   output logic [POS_W-1:0]        out_pos,
   output logic                    out_final,
   output logic                    out_ovf
);

   logic signed [VAL_W-1:0] value_mem [MAX_ITEMS];
   logic [IDX_W-1:0]        order_mem [MAX_ITEMS];

   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    ovf_ff, ovf_in;
   logic [MAX_ITEMS-1:0]    ranked_ff, ranked_in;
   logic [IDX_W-1:0]        scan_idx_ff, scan_idx_in;
   logic [IDX_W-1:0]        rank_ff, rank_in;
   logic [IDX_W-1:0]        emit_ff, emit_in;
   logic                    rd_vld_ff;
   logic [IDX_W-1:0]        rd_idx_ff;
   logic signed [VAL_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]        rd_addr;
   logic                    found_ff, found_in;
   logic [IDX_W-1:0]        best_ff, best_in;
   logic signed [VAL_W-1:0] best_val_ff, best_val_in;
   logic [IDX_W-1:0]        order_q_ff;
   logic                    out_valid_ff, out_valid_in;
   logic signed [VAL_W-1:0] out_value_ff;
   logic [POS_W-1:0]        out_pos_ff;
   logic                    out_final_ff, out_ovf_ff;
   logic [IDX_W-1:0]        last_idx;
   logic                    accept, store_room, take_it;

   assign last_idx   = IDX_W'(count_ff - CNT_W'(1));
   assign in_ready   = cmd.load_en;
   assign accept     = in_valid & cmd.load_en;
   assign store_room = (count_ff < CNT_W'(MAX_ITEMS));
   assign rd_addr    = cmd.emit_val ? order_q_ff : scan_idx_ff;

   assign take_it = rd_vld_ff & ~ranked_ff[rd_idx_ff] &
                    (~found_ff | (rd_data_ff < best_val_ff));

   always_comb begin
      sts.last_accepted = accept & in_last;
      sts.scan_last     = (scan_idx_ff == last_idx);
      sts.rank_last     = (rank_ff == last_idx);
      sts.emit_last     = (emit_ff == last_idx);
      sts.out_free      = ~out_valid_ff | out_ready;
   end

   always_comb begin
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      ranked_in   = ranked_ff;
      scan_idx_in = scan_idx_ff;
      rank_in     = rank_ff;
      emit_in     = emit_ff;
      found_in    = found_ff;
      best_in     = best_ff;
      best_val_in = best_val_ff;
      if (accept) begin
         if (store_room) count_in = count_ff + CNT_W'(1);
         else ovf_in = 1'b1;
      end
      if (cmd.scan_issue) scan_idx_in = scan_idx_ff + IDX_W'(1);
      if (take_it) begin
         found_in    = 1'b1;
         best_in     = rd_idx_ff;
         best_val_in = rd_data_ff;
      end
      if (cmd.commit) begin
         ranked_in[best_ff] = 1'b1;
         rank_in            = rank_ff + IDX_W'(1);
         scan_idx_in        = '0;
         found_in           = 1'b0;
      end
      if (cmd.emit_load) emit_in = emit_ff + IDX_W'(1);
      if (cmd.finish) begin
         count_in  = '0;
         ovf_in    = 1'b0;
         ranked_in = '0;
         rank_in   = '0;
         emit_in   = '0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_valid_ff & out_ready) out_valid_in = 1'b0;
      if (cmd.emit_load) out_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         ranked_ff    <= '0;
         scan_idx_ff  <= '0;
         rank_ff      <= '0;
         emit_ff      <= '0;
         found_ff     <= 1'b0;
         rd_vld_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         ranked_ff    <= ranked_in;
         scan_idx_ff  <= scan_idx_in;
         rank_ff      <= rank_in;
         emit_ff      <= emit_in;
         found_ff     <= found_in;
         rd_vld_ff    <= cmd.scan_issue;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff     <= best_in;
      best_val_ff <= best_val_in;
      rd_idx_ff   <= scan_idx_ff;
      if (cmd.emit_load) begin
         out_value_ff <= rd_data_ff;
         out_pos_ff   <= POS_W'(order_q_ff);
         out_final_ff <= sts.emit_last;
         out_ovf_ff   <= ovf_ff;
      end
   end

   // value store: one write port, one registered read port
   // read data holds while the output register is stalled
   always_ff @(posedge clock) begin
      if (accept & store_room) value_mem[count_ff[IDX_W-1:0]] <= in_number;
      if (cmd.scan_issue | cmd.emit_val) rd_data_ff <= value_mem[rd_addr];
   end

   // rank order: slot r holds the load position of rank r
   always_ff @(posedge clock) begin
      if (cmd.commit) order_mem[rank_ff] <= best_ff;
      if (cmd.emit_ord) order_q_ff <= order_mem[emit_ff];
   end

   assign out_valid = out_valid_ff;
   assign out_value = out_value_ff;
   assign out_pos   = out_pos_ff;
   assign out_final = out_final_ff;
   assign out_ovf   = out_ovf_ff;

   a_commit_found: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> found_ff && !ranked_ff[best_ff])
      else $error("commit without an unranked minimum");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ITEMS))
      else $error("item count beyond capacity");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ready |=> $stable(out_value_ff) && $stable(out_pos_ff))
      else $error("pending result overwritten");

endmodule

@@ hw/rtl/rank_then_radix_sort.sv @@
// Sorts a set of signed 32-bit numbers. Numbers stream in one transaction per cycle until
// the one with req_tlast; at most MAX_ITEMS (64) are kept, later ones are dropped and the
// set's results carry rsp_tuser = 1. The set is then ranked by repeated minimum search
// over the value memory (one entry per cycle, equal values keep load order); each rank
// takes a full scan of the stored items through the single read port of the value memory.
// Results then leave in ascending order, each going through order lookup, value lookup and
// the output register; each carries its load position and rsp_tlast marks the last one.
// New input is taken only after the last result of a set has entered the output register.
module rank_then_radix_sort
   import rtrs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] number
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] sorted_value, [37:32] source_position, zero pad
   output logic        rsp_tlast,
   output logic [0:0]  rsp_tuser    // [0] overflowed
);

   cmd_type                 cmd;
   sts_type                 sts;
   logic signed [VAL_W-1:0] out_value;
   logic [POS_W-1:0]        out_pos;
   logic                    out_ovf;

   // sequencer: load, rank scan, emit
   rtrs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   // stores, counters, minimum search and output register
   rtrs_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_number (req_tdata),
      .in_last   (req_tlast),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_value (out_value),
      .out_pos   (out_pos),
      .out_final (rsp_tlast),
      .out_ovf   (out_ovf)
   );

   assign rsp_tdata = {2'b00, out_pos, out_value};
   assign rsp_tuser = out_ovf;

endmodule

@@ tb/sv/tb_rank_then_radix_sort.sv @@
module tb_rank_then_radix_sort;
   import rtrs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [31:0]      value;
      logic [POS_W-1:0] position;
      logic             final_flag;
      logic             dropped;
   } sorted_entry_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // [31:0] sorted_value, [37:32] source_position, zero pad
   logic        rsp_tlast;
   logic [0:0]  rsp_tuser;   // [0] overflowed

   // expected sorted output, oldest first
   sorted_entry_type sorted_queue[$];

   // model copy of the set being loaded
   logic [31:0] set_values[MAX_ITEMS];
   int          set_count;
   logic        set_dropped;

   int  send_idle_pct;
   int  recv_idle_pct;
   bit  recv_hold;
   int  error_count;
   longint cycle_count;

   rank_then_radix_sort uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // ranks the loaded set, then does the binary radix passes on ranks and
   // queues one expected result per stored value
   task automatic sort_loaded_set();
      logic [6:0]       rank_of[MAX_ITEMS];
      logic [POS_W-1:0] walk_order[MAX_ITEMS];
      logic [POS_W-1:0] zeros[MAX_ITEMS];
      logic [POS_W-1:0] ones[MAX_ITEMS];
      int               best;
      int               bit_count;
      int               nz;
      int               no;
      sorted_entry_type entry;
      for (int i = 0; i < set_count; i++) rank_of[i] = 7'd127;
      // minimum search, ties keep load order (strict less than)
      for (int r = 0; r < set_count; r++) begin
         best = -1;
         for (int i = 0; i < set_count; i++) begin
            if (rank_of[i] == 7'd127 &&
                (best < 0 || $signed(set_values[i]) < $signed(set_values[best]))) begin
               best = i;
            end
         end
         rank_of[best] = r[6:0];
      end
      for (int j = 0; j < set_count; j++) walk_order[j] = j[POS_W-1:0];
      bit_count = 0;
      while (bit_count < 7 && ((set_count - 1) >> bit_count) != 0) bit_count++;
      for (int b = 0; b < bit_count; b++) begin
         nz = 0;
         no = 0;
         for (int j = 0; j < set_count; j++) begin
            if (rank_of[walk_order[j]][b]) begin
               ones[no] = walk_order[j];
               no++;
            end else begin
               zeros[nz] = walk_order[j];
               nz++;
            end
         end
         for (int j = 0; j < nz; j++) walk_order[j] = zeros[j];
         for (int j = 0; j < no; j++) walk_order[nz + j] = ones[j];
      end
      for (int k = 0; k < set_count; k++) begin
         entry.value      = set_values[walk_order[k]];
         entry.position   = walk_order[k];
         entry.final_flag = (k + 1 == set_count);
         entry.dropped    = set_dropped;
         sorted_queue.push_back(entry);
      end
      set_count   = 0;
      set_dropped = 1'b0;
   endtask

   // drives one number, waits for the transaction, updates the model
   task automatic send_number(input logic [31:0] number, input logic is_last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= number;
      req_tlast  <= is_last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (set_count < MAX_ITEMS) begin
         set_values[set_count] = number;
         set_count++;
      end else begin
         set_dropped = 1'b1;
      end
      if (is_last) sort_loaded_set();
   endtask

   // sender pause until every expected result has left
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sorted_queue.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [31:0] random_number();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom_range(7) - 3;   // many duplicates
         default: return $urandom();
      endcase
   endfunction

   task automatic send_set(input int length);
      for (int i = 0; i < length; i++) send_number(random_number(), i == length - 1);
   endtask

   task automatic test_directed();
      // single value, no radix pass
      send_number(32'h8000_0000, 1'b1);
      // extremes, sign boundary and ties
      send_number(32'h7fff_ffff, 1'b0);
      send_number(32'h8000_0000, 1'b0);
      send_number(32'h0000_0000, 1'b0);
      send_number(32'hffff_ffff, 1'b0);
      send_number(32'h0000_0001, 1'b0);
      send_number(32'hffff_ffff, 1'b0);
      send_number(32'h7fff_ffff, 1'b1);
      // two equal values keep load order
      send_number(32'h5555_aaaa, 1'b0);
      send_number(32'h5555_aaaa, 1'b1);
      send_number(32'haaaa_5555, 1'b0);
      send_number(32'h1234_5678, 1'b1);
      wait_drained();
   endtask

   // full store plus dropped items, last one dropped too
   task automatic test_overflow();
      for (int i = 0; i < MAX_ITEMS + 3; i++) begin
         send_number(random_number(), i == MAX_ITEMS + 2);
      end
      // exactly full, nothing dropped
      send_set(MAX_ITEMS);
      wait_drained();
   endtask

   // receiver stops for a long stretch while the sender keeps offering sets
   task automatic test_backpressure();
      recv_hold = 1'b1;
      fork
         begin
            repeat (600) @(posedge clock);
            recv_hold = 1'b0;
         end
         begin
            send_set(5);
            send_set(9);
            send_set(3);
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      join
      wait_drained();
   endtask

   task automatic test_random(input int item_budget);
      int sent;
      int length;
      sent = 0;
      while (sent < item_budget) begin
         length = ($urandom_range(9) == 0) ? $urandom_range(MAX_ITEMS, 40)
                                          : $urandom_range(12, 1);
         send_set(length);
         sent += length;
      end
   endtask

   // result checker
   always @(posedge clock) begin
      sorted_entry_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (sorted_queue.size() == 0) begin
            $display("%0t unexpected result value=%h pos=%0d", $time,
                     rsp_tdata[31:0], rsp_tdata[37:32]);
            error_count++;
         end else begin
            want = sorted_queue.pop_front();
            if (rsp_tdata[31:0] !== want.value) begin
               $display("%0t value expected %h actual %h", $time, want.value,
                        rsp_tdata[31:0]);
               error_count++;
            end
            if (rsp_tdata[37:32] !== want.position) begin
               $display("%0t position expected %0d actual %0d", $time, want.position,
                        rsp_tdata[37:32]);
               error_count++;
            end
            if (rsp_tlast !== want.final_flag) begin
               $display("%0t last expected %b actual %b", $time, want.final_flag,
                        rsp_tlast);
               error_count++;
            end
            if (rsp_tuser[0] !== want.dropped) begin
               $display("%0t overflowed expected %b actual %b", $time, want.dropped,
                        rsp_tuser[0]);
               error_count++;
            end
         end
      end
   end

   // receiver readiness
   always @(posedge clock) begin
      if (reset || recv_hold) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 2_000_000) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      error_count   = 0;
      cycle_count   = 0;
      set_count     = 0;
      set_dropped   = 1'b0;
      recv_hold     = 1'b0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      rsp_tready <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 27;
      recv_idle_pct = 61;
      test_directed();
      test_overflow();
      test_backpressure();
      test_random(60);
      send_idle_pct = 61;
      recv_idle_pct = 27;
      test_random(60);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(60);

      wait_drained();
      repeat (300) @(posedge clock);
      if (error_count == 0 && sorted_queue.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
